// ===== rtl/interval_set_table_defines.svh =====
// assertion macros used by interval_set_table
`ifndef INTERVAL_SET_TABLE_DEFINES_SVH
`define INTERVAL_SET_TABLE_DEFINES_SVH
// clocked implication check with synchronous reset disable
`define IST_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication check
`define IST_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ===== rtl/ist_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package ist_pkg;
   localparam int MaxIntervalsDefault = 64;
   localparam logic [3:0] KIND_HAS = 4'd0;
   localparam logic [3:0] KIND_FIRST = 4'd1;
   localparam logic [3:0] KIND_NEXT = 4'd2;
   localparam logic [3:0] KIND_LAST = 4'd3;
   localparam logic [3:0] KIND_PREV = 4'd4;
   localparam logic [3:0] KIND_PREV_MISSING = 4'd5;
   localparam logic [3:0] KIND_ADD = 4'd6;
   localparam logic [3:0] KIND_ADD_RANGE = 4'd7;
   localparam logic [3:0] KIND_REMOVE = 4'd8;
   localparam logic [3:0] KIND_COUNT = 4'd9;
   localparam logic [31:0] TOP_VALUE = 32'hFFFF_FFFF;
   typedef struct packed {
      logic [31:0] lo;
      logic [31:0] hi;
   } span_type;
endpackage
`default_nettype wire

// ===== rtl/ist_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ist_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  wire                      clock,
   input  wire                      wr_en,
   input  wire  [$clog2(DEPTH)-1:0] wr_addr,
   input  wire  [WIDTH-1:0]         wr_data,
   input  wire  [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ===== rtl/interval_set_table.sv =====
`timescale 1ns / 1ps
// interval_set_table: a set of 32-bit numbers kept as a sorted table of disjoint,
// non-adjacent inclusive intervals in one ram (start/end per row). one transaction
// is handled at a time by a sequencer that walks the table through a single read
// port and a single write port. a query scans the table row by row, reading each
// row in S_SCAN and comparing it in S_EVAL. a change scans the same way and then
// moves rows: each row moved up to open a gap is read in S_SHR and written in
// S_SHRW, and rows moved down to close one stream through S_SHLW behind the
// registered ram read port. a new request is taken only once the previous result
// has been taken. the table needs no clearing pass: the interval count alone
// decides which rows are live.
`default_nettype none
`include "interval_set_table_defines.svh"
module interval_set_table #(
   parameter int MAX_INTERVALS = ist_pkg::MaxIntervalsDefault
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [3:0]  req_kind,
   input  wire  [31:0] req_value,
   input  wire  [31:0] req_range_end,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic        rsp_found,
   output logic [31:0] rsp_answer,
   output logic [32:0] rsp_member_total,
   output logic        rsp_status
);
   localparam int AW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
   localparam int CW = $clog2(MAX_INTERVALS + 1);
   localparam logic [CW-1:0] MAXC = CW'(MAX_INTERVALS);

   // sequencer states
   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_SCAN = 4'd1;   // issue read of row idx
   localparam logic [3:0] S_EVAL = 4'd2;   // examine read data
   localparam logic [3:0] S_MERGE = 4'd3;  // scan rows lo.. to find hi
   localparam logic [3:0] S_MEVAL = 4'd4;
   localparam logic [3:0] S_SHR = 4'd5;    // shift up (open a gap)
   localparam logic [3:0] S_SHRW = 4'd6;
   localparam logic [3:0] S_SHL = 4'd7;    // shift down (close a gap)
   localparam logic [3:0] S_SHLW = 4'd8;
   localparam logic [3:0] S_DONE = 4'd9;

   logic [3:0]  state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;       // interval count
   logic [CW-1:0] idx_ff, idx_in;       // walking index
   logic [CW-1:0] lo_ff, lo_in;         // target row
   logic [CW-1:0] gone_ff, gone_in;     // rows removed by a merge
   logic [3:0]  kind_ff, kind_in;
   logic [31:0] a_ff, a_in, b_ff, b_in;
   logic [31:0] lastend_ff, lastend_in; // end of last merged row
   logic        found_ff, found_in, status_ff, status_in;
   logic [31:0] answer_ff, answer_in;
   logic [32:0] total_ff, total_in;
   logic        split_ff, split_in;     // remove split pending / shift data valid
   logic        out_v_ff, out_v_in;

   logic            wr_en;
   logic [AW-1:0]   wr_addr, rd_addr;
   ist_pkg::span_type wr_data, rd_data;

   ist_ram #(.WIDTH(64), .DEPTH(MAX_INTERVALS)) u_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   // interval size: one 33-bit hi - lo + 1 computation
   logic [32:0] diff;
   assign diff = {1'b0, rd_data.hi} - {1'b0, rd_data.lo} + 33'd1;

   // busy, or the last result still waits to be taken
   assign req_stall = (state_ff != S_IDLE) || out_v_ff;
   assign rsp_valid = out_v_ff;
   assign rsp_found = found_ff;
   assign rsp_answer = answer_ff;
   assign rsp_member_total = total_ff;
   assign rsp_status = status_ff;

   logic is_last;
   assign is_last = (idx_ff + CW'(1) >= cnt_ff);

   always_comb begin
      state_in = state_ff; cnt_in = cnt_ff; idx_in = idx_ff; lo_in = lo_ff;
      gone_in = gone_ff; kind_in = kind_ff; a_in = a_ff; b_in = b_ff;
      lastend_in = lastend_ff; found_in = found_ff; status_in = status_ff;
      answer_in = answer_ff; total_in = total_ff; split_in = split_ff;
      out_v_in = out_v_ff;
      wr_en = 1'b0; wr_addr = lo_ff[AW-1:0]; wr_data = '{lo: a_ff, hi: b_ff};
      rd_addr = idx_ff[AW-1:0];
      if (out_v_ff && !rsp_stall) out_v_in = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && !req_stall) begin
               kind_in = req_kind; a_in = req_value; b_in = req_range_end;
               found_in = 1'b0; answer_in = '0; total_in = '0; status_in = 1'b0;
               idx_in = '0; split_in = 1'b0;
               if (req_kind == ist_pkg::KIND_ADD) b_in = req_value;
               if (req_kind == ist_pkg::KIND_PREV_MISSING) a_in = req_value - 32'd1;
               if (req_kind == ist_pkg::KIND_LAST || req_kind == ist_pkg::KIND_PREV)
                  idx_in = cnt_ff - CW'(1);
               state_in = S_SCAN;
               if (req_kind > ist_pkg::KIND_COUNT) state_in = S_DONE;
               if ((req_kind == ist_pkg::KIND_NEXT && req_value == ist_pkg::TOP_VALUE) ||
                   ((req_kind == ist_pkg::KIND_PREV ||
                     req_kind == ist_pkg::KIND_PREV_MISSING) && req_value == '0) ||
                   (req_kind == ist_pkg::KIND_ADD_RANGE && req_value > req_range_end))
                  state_in = S_DONE;
            end
         end
         S_SCAN: begin
            if (idx_ff >= cnt_ff || cnt_ff == '0) begin
               // walked off the table
               state_in = S_DONE;
               unique case (kind_ff) inside
                  ist_pkg::KIND_PREV_MISSING: begin found_in = 1'b1; answer_in = a_ff; end
                  ist_pkg::KIND_ADD, ist_pkg::KIND_ADD_RANGE: begin
                     lo_in = cnt_ff;
                     if (cnt_ff >= MAXC) status_in = 1'b1;
                     else begin idx_in = cnt_ff; state_in = S_SHR; end
                  end
                  default: ;
               endcase
            end else state_in = S_EVAL;
         end
         S_EVAL: begin
            state_in = S_SCAN;
            idx_in = idx_ff + CW'(1);
            unique case (kind_ff) inside
               ist_pkg::KIND_HAS: begin
                  if (rd_data.lo <= a_ff && a_ff <= rd_data.hi) begin
                     found_in = 1'b1; state_in = S_DONE;
                  end
               end
               ist_pkg::KIND_FIRST: begin
                  found_in = 1'b1; answer_in = rd_data.lo; state_in = S_DONE;
               end
               ist_pkg::KIND_LAST: begin
                  found_in = 1'b1; answer_in = rd_data.hi; state_in = S_DONE;
               end
               ist_pkg::KIND_NEXT: begin
                  if (rd_data.lo > a_ff) begin
                     found_in = 1'b1; answer_in = rd_data.lo; state_in = S_DONE;
                  end else if (rd_data.hi > a_ff) begin
                     found_in = 1'b1; answer_in = a_ff + 32'd1; state_in = S_DONE;
                  end
               end
               ist_pkg::KIND_PREV: begin
                  if (rd_data.hi < a_ff) begin
                     found_in = 1'b1; answer_in = rd_data.hi; state_in = S_DONE;
                  end else if (rd_data.lo < a_ff) begin
                     found_in = 1'b1; answer_in = a_ff - 32'd1; state_in = S_DONE;
                  end else if (idx_ff == '0) state_in = S_DONE;
                  else idx_in = idx_ff - CW'(1);
               end
               ist_pkg::KIND_PREV_MISSING: begin
                  if (rd_data.lo <= a_ff && a_ff <= rd_data.hi) begin
                     state_in = S_DONE;
                     if (rd_data.lo != '0) begin
                        found_in = 1'b1; answer_in = rd_data.lo - 32'd1;
                     end
                  end
               end
               ist_pkg::KIND_COUNT: total_in = total_ff + diff;
               ist_pkg::KIND_ADD, ist_pkg::KIND_ADD_RANGE: begin
                  if (a_ff == '0 || rd_data.hi >= a_ff - 32'd1) begin
                     lo_in = idx_ff;
                     if (b_ff == ist_pkg::TOP_VALUE || rd_data.lo <= b_ff + 32'd1) begin
                        if (rd_data.lo < a_ff) a_in = rd_data.lo;
                        lastend_in = rd_data.hi;
                        gone_in = '0;
                        state_in = S_MERGE;
                     end else begin
                        // insert before this row
                        if (cnt_ff >= MAXC) begin status_in = 1'b1; state_in = S_DONE; end
                        else begin idx_in = cnt_ff; state_in = S_SHR; end
                     end
                  end
               end
               ist_pkg::KIND_REMOVE: begin
                  if (rd_data.lo <= a_ff && a_ff <= rd_data.hi) begin
                     lo_in = idx_ff;
                     state_in = S_DONE;
                     if (rd_data.lo == a_ff && rd_data.hi == a_ff) begin
                        gone_in = CW'(1); state_in = S_SHL;
                     end else if (rd_data.lo == a_ff) begin
                        wr_en = 1'b1; wr_addr = idx_ff[AW-1:0];
                        wr_data = '{lo: a_ff + 32'd1, hi: rd_data.hi};
                     end else if (rd_data.hi == a_ff) begin
                        wr_en = 1'b1; wr_addr = idx_ff[AW-1:0];
                        wr_data = '{lo: rd_data.lo, hi: a_ff - 32'd1};
                     end else if (cnt_ff >= MAXC) status_in = 1'b1;
                     else begin
                        wr_en = 1'b1; wr_addr = idx_ff[AW-1:0];
                        wr_data = '{lo: rd_data.lo, hi: a_ff - 32'd1};
                        lo_in = idx_ff + CW'(1);
                        a_in = a_ff + 32'd1; b_in = rd_data.hi;
                        split_in = 1'b1;
                        idx_in = cnt_ff; state_in = S_SHR;
                     end
                  end
               end
               default: state_in = S_DONE;
            endcase
            if (is_last && state_in == S_SCAN && kind_ff == ist_pkg::KIND_COUNT)
               state_in = S_DONE;
         end
         S_MERGE: begin
            // idx points at the row after the last merged one
            if (idx_ff >= cnt_ff) begin
               state_in = S_SHL;
               if (lastend_ff > b_ff) b_in = lastend_ff;
            end else state_in = S_MEVAL;
         end
         S_MEVAL: begin
            if (b_ff == ist_pkg::TOP_VALUE || rd_data.lo <= b_ff + 32'd1) begin
               lastend_in = rd_data.hi; gone_in = gone_ff + CW'(1);
               idx_in = idx_ff + CW'(1); state_in = S_MERGE;
            end else begin
               state_in = S_SHL;
               if (lastend_ff > b_ff) b_in = lastend_ff;
            end
         end
         S_SHR: begin
            // idx is the destination row, moving down toward lo
            if (idx_ff == lo_ff) begin
               wr_en = 1'b1; wr_addr = lo_ff[AW-1:0];
               wr_data = '{lo: a_ff, hi: b_ff};
               cnt_in = cnt_ff + CW'(1);
               state_in = S_DONE;
            end else begin
               rd_addr = AW'(idx_ff - CW'(1));
               state_in = S_SHRW;
            end
         end
         S_SHRW: begin
            wr_en = 1'b1; wr_addr = idx_ff[AW-1:0]; wr_data = rd_data;
            idx_in = idx_ff - CW'(1); state_in = S_SHR;
         end
         S_SHL: begin
            // merge: write row lo (unless a plain delete), then close gone rows
            if (kind_ff != ist_pkg::KIND_REMOVE && idx_ff >= lo_ff) begin
               wr_en = 1'b1; wr_addr = lo_ff[AW-1:0]; wr_data = '{lo: a_ff, hi: b_ff};
            end
            if (gone_ff == '0) state_in = S_DONE;
            else begin
               idx_in = (kind_ff == ist_pkg::KIND_REMOVE) ? lo_ff : lo_ff + CW'(1);
               lo_in = ~CW'(0); // mark header written
               state_in = S_SHLW;
            end
         end
         S_SHLW: begin
            // read idx+gone; in the next cycle the read data is written at row idx-1
            if (idx_ff + gone_ff >= cnt_ff) begin
               cnt_in = cnt_ff - gone_ff; state_in = S_DONE;
            end else begin
               rd_addr = AW'(idx_ff + gone_ff);
               state_in = S_SHLW;
               if (split_ff) begin
                  wr_en = 1'b1; wr_addr = AW'(idx_ff - CW'(1)); wr_data = rd_data;
               end
               split_in = 1'b1;
               idx_in = idx_ff + CW'(1);
            end
            if (state_in == S_DONE && split_ff) begin
               wr_en = 1'b1; wr_addr = AW'(idx_ff - CW'(1)); wr_data = rd_data;
            end
         end
         S_DONE: begin
            if (!out_v_ff || !rsp_stall) begin
               out_v_in = 1'b1; state_in = S_IDLE; split_in = 1'b0;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; cnt_ff <= '0; out_v_ff <= 1'b0; split_ff <= 1'b0;
      end else begin
         state_ff <= state_in; cnt_ff <= cnt_in; out_v_ff <= out_v_in;
         split_ff <= split_in;
      end
      idx_ff <= idx_in; lo_ff <= lo_in; gone_ff <= gone_in; kind_ff <= kind_in;
      a_ff <= a_in; b_ff <= b_in; lastend_ff <= lastend_in; found_ff <= found_in;
      status_ff <= status_in; answer_ff <= answer_in; total_ff <= total_in;
   end

   `IST_ASSERT_IMP(a_cnt_range, clock, reset, 1'b1, cnt_ff <= MAXC, "count overflow")
   `IST_ASSERT_IMP(a_busy_stall, clock, reset, state_ff != S_IDLE, req_stall, "busy but ready")
   `IST_ASSERT_NXT(a_accept_busy, clock, reset, req_valid && !req_stall,
      state_ff != S_IDLE, "accepted but idle")
endmodule
`default_nettype wire
